// ===== rtl/stream_pattern_masker_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stream pattern masker
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef STREAM_PATTERN_MASKER_CORE_ASSERT_SVH
`define STREAM_PATTERN_MASKER_CORE_ASSERT_SVH

// same-cycle implication, switched off while reset is asserted
`define SPM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, switched off while reset is asserted
`define SPM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also runs through reset
`define SPM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/spm_pkg.sv =====
// ----------------------------------------------------------------------------
// spm_pkg
// Shared constants and types of the stream pattern masker.
// ----------------------------------------------------------------------------
package spm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int SRC_W       = LEN_W + 1;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_W-1:0] MASK_BYTE = 8'h2A;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW  = 2'd0,
        CFG_PATTERN_HIGH = 2'd1,
        CFG_PATTERN_LEN  = 2'd2
    } cfg_index_t;

    // one queued emit command: a byte repeated reps times
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  reps;
        logic              run_last;
        logic              stream_end;
    } spm_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } spm_q_status_t;

endpackage

// ===== rtl/spm_queue.sv =====
// ----------------------------------------------------------------------------
// spm_queue
// Short command queue between the scanning front and the emitting back.
// ----------------------------------------------------------------------------
module spm_queue
    import spm_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  spm_cmd_t      push_cmd,
    input  logic          pop,
    output spm_cmd_t      head_cmd,
    output spm_q_status_t status
);

    spm_cmd_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    fill_reg, fill_next;

    assign status.full  = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (fill_reg == '0);
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + (push ? QPTR_W'(1) : QPTR_W'(0));
        rd_ptr_next = rd_ptr_reg + (pop ? QPTR_W'(1) : QPTR_W'(0));
        fill_next   = fill_reg + (push ? (QPTR_W+1)'(1) : (QPTR_W+1)'(0))
                               - (pop ? (QPTR_W+1)'(1) : (QPTR_W+1)'(0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/spm_front.sv =====
// ----------------------------------------------------------------------------
// spm_front
// Holds the pattern registers and the pending window; one scan step a cycle while the queue is not full.
// ----------------------------------------------------------------------------
module spm_front
    import spm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,
    input  logic                  s_tlast,
    output logic                  push,
    output spm_cmd_t              push_cmd,
    input  spm_q_status_t         q_status
);

    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;
    logic [LEN_W-1:0]      pat_len_reg;

    logic [BYTE_W-1:0] win_reg [MAX_PATTERN];
    logic [BYTE_W-1:0] win_next [MAX_PATTERN];
    logic [LEN_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              last_reg, last_next;

    logic [BYTE_W-1:0] pat_byte [MAX_PATTERN];
    logic [BYTE_W-1:0] work_win [MAX_PATTERN];
    logic [BYTE_W-1:0] shifted [MAX_PATTERN];
    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  work_cnt;
    logic [LEN_W-1:0]  drop;
    logic [LEN_W-1:0]  new_cnt;
    logic              work_last;
    logic              take;
    logic              act;
    logic              hit;
    logic              full_win;
    logic              has_action;
    logic              more;
    logic [SRC_W-1:0]  src;

    assign s_tready = !busy_reg && !q_status.full;
    assign take     = s_tvalid && s_tready;
    assign act      = take || (busy_reg && !q_status.full);

    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (k < MAX_PATTERN / 2) begin
                pat_byte[k] = pat_low_reg[k*BYTE_W +: BYTE_W];
            end else begin
                pat_byte[k] = pat_high_reg[(k - MAX_PATTERN/2)*BYTE_W +: BYTE_W];
            end
        end
    end

    // clamp the length register into 1..MAX_PATTERN
    always_comb begin
        if (pat_len_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (pat_len_reg > LEN_W'(MAX_PATTERN)) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = pat_len_reg;
        end
    end

    // window as seen this cycle: the new word appended on accept
    always_comb begin
        work_win  = win_reg;
        work_cnt  = cnt_reg;
        work_last = last_reg;
        if (take) begin
            work_win[cnt_reg[IDX_W-1:0]] = s_tdata;
            work_cnt  = cnt_reg + LEN_W'(1);
            work_last = s_tlast;
        end
    end

    // one scan step: mask a full match, else emit the oldest byte
    always_comb begin
        hit = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (LEN_W'(k) < eff_len && work_win[k] != pat_byte[k]) begin
                hit = 1'b0;
            end
        end
        full_win   = (work_cnt >= eff_len);
        has_action = full_win || (work_last && work_cnt != '0);

        push_cmd = '0;
        if (full_win && hit) begin
            drop          = eff_len;
            push_cmd.data = MASK_BYTE;
            push_cmd.reps = eff_len;
        end else begin
            drop          = LEN_W'(1);
            push_cmd.data = work_win[0];
            push_cmd.reps = LEN_W'(1);
        end
        new_cnt = work_cnt - drop;
        more    = (new_cnt >= eff_len) || (work_last && new_cnt != '0);
        push_cmd.run_last   = !more;
        push_cmd.stream_end = !more && work_last;
        push = act && has_action;
    end

    always_comb begin
        src = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            src = SRC_W'(i) + {1'b0, drop};
            if (src < SRC_W'(MAX_PATTERN)) begin
                shifted[i] = work_win[src[IDX_W-1:0]];
            end else begin
                shifted[i] = '0;
            end
        end
    end

    always_comb begin
        win_next  = win_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        last_next = last_reg;
        if (act) begin
            last_next = work_last;
            if (has_action) begin
                win_next  = shifted;
                cnt_next  = new_cnt;
                busy_next = more;
            end else begin
                win_next  = work_win;
                cnt_next  = work_cnt;
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            busy_reg     <= 1'b0;
            last_reg     <= 1'b0;
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            pat_len_reg  <= LEN_W'(1);
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            last_reg <= last_next;
            if (cfg_wr_en) begin
                case (cfg_index_t'(cfg_wr_index))
                    CFG_PATTERN_LOW:  pat_low_reg  <= cfg_wr_data;
                    CFG_PATTERN_HIGH: pat_high_reg <= cfg_wr_data;
                    CFG_PATTERN_LEN:  pat_len_reg  <= cfg_wr_data[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule

// ===== rtl/spm_back.sv =====
// ----------------------------------------------------------------------------
// spm_back
// Expands queued commands into output words behind a register stage.
// ----------------------------------------------------------------------------
module spm_back
    import spm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  spm_cmd_t          head_cmd,
    input  spm_q_status_t     q_status,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;
    logic              out_user_reg;
    logic [LEN_W-1:0]  rep_reg, rep_next;
    logic              load;
    logic              final_rep;

    assign load      = !q_status.empty && (!out_valid_reg || m_tready);
    assign final_rep = ((rep_reg + LEN_W'(1)) == head_cmd.reps);
    assign pop       = load && final_rep;

    always_comb begin
        out_valid_next = out_valid_reg;
        rep_next       = rep_reg;
        if (load) begin
            out_valid_next = 1'b1;
            rep_next       = final_rep ? '0 : rep_reg + LEN_W'(1);
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            rep_reg       <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            rep_reg       <= rep_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= head_cmd.data;
            out_last_reg <= final_rep && head_cmd.run_last;
            out_user_reg <= final_rep && head_cmd.stream_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== rtl/stream_pattern_masker_core.sv =====
// ----------------------------------------------------------------------------
// stream_pattern_masker_core: masks pattern occurrences in a byte stream
// Path: input handshake through the queue entry and the output register to the first output word of a step.
// Throughput: 1 word/cycle while m_tready holds; input held during extra scan steps, or while queue full.
// Reset: synchronous, active low; empties window and queue, clears pattern, length 1.
// ----------------------------------------------------------------------------
module stream_pattern_masker_core
    import spm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // stream_last
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [BYTE_W-1:0]     m_tdata,   // [7:0] out_byte
    output logic                  m_tlast,   // run_last
    output logic                  m_tuser    // [0] stream_end
);

    // Front: appends each word to the pending window and performs one scan
    // step a cycle while the queue is not full (mask a full match, pass the oldest byte, or flush one
    // pending byte at stream end). Each step queues one emit command.
    logic          push;
    spm_cmd_t      push_cmd;
    logic          pop;
    spm_cmd_t      head_cmd;
    spm_q_status_t q_status;

    spm_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .push         (push),
        .push_cmd     (push_cmd),
        .q_status     (q_status)
    );

    // Queue: decouples scanning from output back-pressure.
    spm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    // Back: repeat each command's byte, tag the final word of a run and of
    // the stream, and hold the word in the output register until taken.
    spm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/spm_checker.sv =====
// ----------------------------------------------------------------------------
// spm_checker
// Port-level checks on the result stream of the pattern masker.
// ----------------------------------------------------------------------------
`include "stream_pattern_masker_core_assert.svh"

module spm_checker
    import spm_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [BYTE_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic              m_tuser
);

    `SPM_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "word dropped while stalled")
    `SPM_ASSERT_NEXT(a_hold_word, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "word changed while stalled")
    `SPM_ASSERT_IMP(a_end_is_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast, "stream end without run end")
    `SPM_ASSERT_NEXT_ALWAYS(a_reset_idle, aclk, !aresetn, !m_tvalid, "output valid after reset")

endmodule

bind stream_pattern_masker_core spm_checker u_spm_checker (.*);
